### sv/shss_pkg.sv
package shss_pkg;

   // Sequencer dimensions
   localparam int NUM_PHASES = 8;
   localparam int NUM_SPEEDS = 5;

   localparam int PHASE_W  = 3;
   localparam int COIL_W   = 4;
   localparam int COUNT_W  = 8;
   localparam int SPEED_W  = 3;
   localparam int DIR_W    = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 3;

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_INDEX = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION   = 2'd1;

   localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(NUM_PHASES - 1);
   localparam logic [SPEED_W-1:0] LAST_SPEED = SPEED_W'(NUM_SPEEDS - 1);

   typedef struct packed {
      logic [SPEED_W-1:0] speed_index;
      logic [DIR_W-1:0]   direction;
   } cfg_type;

   typedef struct packed {
      logic               emit;
      logic [COIL_W-1:0]  coil_pattern;
      logic [PHASE_W-1:0] phase_index;
   } step_type;

   // Half-step coil drive pattern for each phase
   function automatic logic [COIL_W-1:0] coil_lookup(input logic [PHASE_W-1:0] ph);
      logic [COIL_W-1:0] pat;
      case (ph)
         3'd0:    pat = 4'h1;
         3'd1:    pat = 4'h3;
         3'd2:    pat = 4'h2;
         3'd3:    pat = 4'h6;
         3'd4:    pat = 4'h4;
         3'd5:    pat = 4'hc;
         3'd6:    pat = 4'h8;
         default: pat = 4'h9;
      endcase
      return pat;
   endfunction

   // Step period in ticks for each speed setting
   function automatic logic [COUNT_W-1:0] period_lookup(input logic [SPEED_W-1:0] idx);
      logic [COUNT_W-1:0] per;
      case (idx)
         3'd0:    per = 8'd250;
         3'd1:    per = 8'd125;
         3'd2:    per = 8'd83;
         3'd3:    per = 8'd43;
         default: per = 8'd25;
      endcase
      return per;
   endfunction

endpackage

### sv/shss_csr_regs.sv
module shss_csr_regs (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [shss_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [shss_pkg::CSR_DATA_W-1:0]  csr_data,
   output shss_pkg::cfg_type                cfg
);

   shss_pkg::cfg_type cfg_ff;
   shss_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the write; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            shss_pkg::CSR_SPEED_INDEX: cfg_in.speed_index = csr_data;
            shss_pkg::CSR_DIRECTION:   cfg_in.direction   = csr_data[shss_pkg::DIR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_index <= '0;
         cfg_ff.direction   <= shss_pkg::DIR_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### sv/shss_step_core.sv
module shss_step_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               tick,
   input  logic               run_enable,
   input  shss_pkg::cfg_type  cfg,
   output shss_pkg::step_type step
);

   logic [shss_pkg::COUNT_W-1:0] tick_count_ff, tick_count_in;
   logic [shss_pkg::PHASE_W-1:0] phase_ff, phase_in;

   logic                         counted;
   logic [shss_pkg::SPEED_W-1:0] speed_sel;
   logic [shss_pkg::COUNT_W-1:0] period;
   logic [shss_pkg::COUNT_W-1:0] count_inc;
   logic                         hit;
   logic [shss_pkg::PHASE_W-1:0] ph;
   logic [shss_pkg::PHASE_W-1:0] ph_next;

   // Count only when running with a speed and a direction
   assign counted   = run_enable && (cfg.speed_index != '0) && (cfg.direction != '0);
   assign speed_sel = (cfg.speed_index > shss_pkg::LAST_SPEED) ? shss_pkg::LAST_SPEED
                                                               : cfg.speed_index;
   assign period    = shss_pkg::period_lookup(speed_sel);
   assign count_inc = tick_count_ff + 1'b1;
   assign hit       = counted && (count_inc >= period);

   // Clamp phase, then step it with wrap; direction sign bit means reverse
   assign ph = (phase_ff > shss_pkg::LAST_PHASE) ? shss_pkg::LAST_PHASE : phase_ff;

   always_comb begin
      if (!cfg.direction[shss_pkg::DIR_W-1]) begin
         ph_next = (ph == shss_pkg::LAST_PHASE) ? '0 : ph + 1'b1;
      end else begin
         ph_next = (ph == '0) ? shss_pkg::LAST_PHASE : ph - 1'b1;
      end
   end

   always_comb begin
      tick_count_in = tick_count_ff;
      phase_in      = phase_ff;
      if (tick && counted) begin
         tick_count_in = hit ? '0 : count_inc;
         if (hit) begin
            phase_in = ph_next;
         end
      end
   end

   assign step.emit         = tick && hit;
   assign step.coil_pattern = shss_pkg::coil_lookup(ph);
   assign step.phase_index  = ph;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= '0;
         phase_ff      <= '0;
      end else begin
         tick_count_ff <= tick_count_in;
         phase_ff      <= phase_in;
      end
   end

endmodule

### sv/stepper_half_step_sequencer.sv
// Half-step stepper motor sequencer.
// Input channel (req_valid/req_ready, req_run_enable): one transaction per
// timer tick. A tick counts when run_enable is set, speed_index is non-zero
// and direction is non-zero; when the count reaches the period of the chosen
// speed, one transaction goes out on the result channel (rsp_valid/rsp_ready)
// with the coil pattern and phase index, and the phase steps with wrap.
// Ticks that do not reach the period produce no result.
// Configuration (csr_valid/csr_ready, csr_index, csr_data) is always ready:
// index 0 is speed_index, index 1 is direction (2-bit signed); write it only
// while the block is idle.
// A tick passes through the input register, then the result register, before
// rsp_valid rises. Throughput: one tick per cycle while rsp_ready is high, set
// by the counter and phase update.
// When the receiver stalls, the result register holds and the input register
// backs up; req_ready drops only while both are full and rsp_ready is low.
// Synchronous reset clears the counter and phase to zero, speed_index to 0
// and direction to forward, and empties both registers.
module stepper_half_step_sequencer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_run_enable,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [shss_pkg::COIL_W-1:0]      rsp_coil_pattern,
   output logic [shss_pkg::PHASE_W-1:0]     rsp_phase_index,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [shss_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [shss_pkg::CSR_DATA_W-1:0]  csr_data
);

   shss_pkg::cfg_type  cfg;
   shss_pkg::step_type step;

   logic                          in_valid_ff, in_valid_in;
   logic                          in_run_ff;
   logic                          out_valid_ff, out_valid_in;
   logic [shss_pkg::COIL_W-1:0]   out_coil_ff;
   logic [shss_pkg::PHASE_W-1:0]  out_phase_ff;
   logic                          advance;

   shss_csr_regs u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   shss_step_core u_core (
      .clock      (clock),
      .reset      (reset),
      .tick       (advance),
      .run_enable (in_run_ff),
      .cfg        (cfg),
      .step       (step)
   );

   // Move the held tick through the core when the result register is free
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = req_valid ? 1'b1 : (in_valid_ff && !advance);
   assign out_valid_in = advance ? step.emit : (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= in_valid_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture payloads
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_run_ff <= req_run_enable;
      end
      if (advance && step.emit) begin
         out_coil_ff  <= step.coil_pattern;
         out_phase_ff <= step.phase_index;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_coil_pattern = out_coil_ff;
   assign rsp_phase_index  = out_phase_ff;

endmodule
